// File: rtl/mchl_pkg.sv
// ----------------------------------------------------------------------------
// mchl_pkg: shared types and constants for the Morton chunk hash lookup
// Field widths, register indexes, function codes, modulo unit sizing and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package mchl_pkg;

    // Parameter defaults
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int AXIS_BITS_DEF   = 10;

    // Field widths
    localparam int KEY_W      = 30;
    localparam int KEY_AXIS_W = KEY_W / 3;
    localparam int COORD_W    = 32;
    localparam int SLOT_W     = 6;
    localparam int SHIFT_W    = 4;
    localparam int TSIZE_W    = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 1'd1;
    localparam logic [SHIFT_W-1:0]   CHUNK_SHIFT_RST = 4'd5;
    localparam logic [TSIZE_W-1:0]   TABLE_SIZE_RST  = 7'd1;

    // Function codes of an input word
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Key modulo unit: MOD_DIGIT_W dividend bits per cycle
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = (KEY_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;
    localparam int MOD_PAD_W   = MOD_STEPS * MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;     // write one empty row of the clearing pass
        logic load_wr;    // write the slot of a load word
        logic capture;    // take key and table size of a lookup word
        logic mod_step;   // one digit step of key modulo size
        logic advance;    // step the probe to the next slot
        logic finish;     // latch the probe outcome
        logic out_load;   // move the outcome into the output register
    } mchl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;     // clearing pass at the last row
        logic probe_empty;  // probed slot is empty
        logic probe_match;  // probed slot holds the key
        logic probe_last;   // this probe is the last one allowed
    } mchl_status_t;

endpackage

// File: rtl/mchl_in_if.sv
// ----------------------------------------------------------------------------
// mchl_in_if: input channel of the chunk hash lookup
// Valid/ready handshake carrying one load or lookup word.
// ----------------------------------------------------------------------------
interface mchl_in_if import mchl_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [SLOT_W-1:0]         slot_number;
    logic [KEY_W-1:0]          slot_key;
    logic                      slot_empty;

    modport source (
        output valid, func, pos_x, pos_y, pos_z, slot_number, slot_key, slot_empty,
        input  ready
    );

    modport sink (
        input  valid, func, pos_x, pos_y, pos_z, slot_number, slot_key, slot_empty,
        output ready
    );

endinterface

// File: rtl/mchl_out_if.sv
// ----------------------------------------------------------------------------
// mchl_out_if: result channel of the chunk hash lookup
// Valid/ready handshake carrying one lookup result word.
// ----------------------------------------------------------------------------
interface mchl_out_if import mchl_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] hit_slot;
    logic [KEY_W-1:0]  chunk_key;

    modport source (
        output valid, found, hit_slot, chunk_key,
        input  ready
    );

    modport sink (
        input  valid, found, hit_slot, chunk_key,
        output ready
    );

endinterface

// File: rtl/mchl_ctrl.sv
// ----------------------------------------------------------------------------
// mchl_ctrl: sequencer of the chunk hash lookup
// Runs the clearing pass, takes input words, steps the key modulo unit and
// the probe walk, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module mchl_ctrl import mchl_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_func,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  mchl_status_t status,
    output mchl_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_LOOKUP)
                    begin
                        cmd.capture = 1'b1;
                        cnt_next    = '0;
                        state_next  = S_MOD;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + MOD_CNT_W'(1);
                if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.probe_empty || status.probe_match || status.probe_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result word until it is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/mchl_dpath.sv
// ----------------------------------------------------------------------------
// mchl_dpath: datapath of the chunk hash lookup
// Morton key build, digit-serial key modulo table size, slot table memory
// with registered read, probe index and count, and the result registers.
// ----------------------------------------------------------------------------
module mchl_dpath import mchl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AXIS_BITS   = AXIS_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mchl_cmd_t                 cmd,
    output mchl_status_t              status,
    input  logic [SHIFT_W-1:0]        chunk_shift,
    input  logic [TSIZE_W-1:0]        table_size,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic [SLOT_W-1:0]         slot_number,
    input  logic [KEY_W-1:0]          slot_key,
    input  logic                      slot_empty,
    output logic                      found,
    output logic [SLOT_W-1:0]         hit_slot,
    output logic [KEY_W-1:0]          chunk_key
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SIZE_MAX = (1 << TSIZE_W) - 1;
    localparam int CAP     = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;
    localparam int CMP_W   = ((IDX_W > TSIZE_W) ? IDX_W : TSIZE_W) + 1;
    localparam int ROW_W   = KEY_W + 1;
    localparam logic [TSIZE_W-1:0] N_CAP     = TSIZE_W'(CAP);
    localparam logic [IDX_W-1:0]   LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);

    // Interleave three chunk coordinates, x lowest
    function automatic logic [KEY_W-1:0] morton(
        input logic [COORD_W-1:0] cx,
        input logic [COORD_W-1:0] cy,
        input logic [COORD_W-1:0] cz
    );
        logic [KEY_W-1:0] k;
        k = '0;
        for (int b = 0; b < KEY_AXIS_W; b++)
        begin
            if (b < AXIS_BITS)
            begin
                k[3*b]     = cx[b];
                k[3*b + 1] = cy[b];
                k[3*b + 2] = cz[b];
            end
        end
        return k;
    endfunction

    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [KEY_W-1:0]          key_in;
    logic [TSIZE_W-1:0]        n_cfg;

    logic [KEY_W-1:0]     key_reg;
    logic [TSIZE_W-1:0]   n_reg;
    logic [MOD_PAD_W-1:0] div_reg, div_next;
    logic [TSIZE_W-1:0]   rem_reg, rem_next;
    logic [TSIZE_W:0]     trial;
    logic [IDX_W-1:0]     idx_reg, idx_wrap;
    logic [CMP_W-1:0]     idx_inc;
    logic [TSIZE_W-1:0]   pcnt_reg;
    logic [IDX_W-1:0]     clr_addr_reg;
    logic                 found_reg;
    logic [SLOT_W-1:0]    hit_reg;
    logic                 out_found_reg;
    logic [SLOT_W-1:0]    out_hit_reg;
    logic [KEY_W-1:0]     out_key_reg;

    logic [ROW_W-1:0] mem [TABLE_DEPTH];
    logic [ROW_W-1:0] rd_reg;
    logic             slot_ok;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;

    // Chunk coordinates and key of the incoming word
    assign cx     = pos_x >>> chunk_shift;
    assign cy     = pos_y >>> chunk_shift;
    assign cz     = pos_z >>> chunk_shift;
    assign key_in = morton(cx, cy, cz);

    // Clamp table size to 1..depth
    always_comb
    begin
        if (table_size == '0)
        begin
            n_cfg = TSIZE_W'(1);
        end
        else if (table_size > N_CAP)
        begin
            n_cfg = N_CAP;
        end
        else
        begin
            n_cfg = table_size;
        end
    end

    // Restoring remainder, MOD_DIGIT_W dividend bits per step
    always_comb
    begin
        rem_next = rem_reg;
        div_next = div_reg;
        trial    = '0;
        for (int j = 0; j < MOD_DIGIT_W; j++)
        begin
            trial    = {rem_next, div_next[MOD_PAD_W-1]};
            div_next = div_next << 1;
            if (trial >= {1'b0, n_reg})
            begin
                trial = trial - {1'b0, n_reg};
            end
            rem_next = trial[TSIZE_W-1:0];
        end
    end

    // Wrap the probe within the table size in use
    assign idx_inc  = CMP_W'(idx_reg) + CMP_W'(1);
    assign idx_wrap = (idx_inc == CMP_W'(n_reg)) ? '0 : IDX_W'(idx_inc);

    // Slot table write port: clearing pass or load word
    assign slot_ok = (32'(slot_number) < TABLE_DEPTH);
    assign wr_en   = cmd.clr_wr || (cmd.load_wr && slot_ok);
    assign wr_addr = cmd.clr_wr ? clr_addr_reg : IDX_W'(slot_number);
    assign wr_data = cmd.clr_wr ? {1'b1, {KEY_W{1'b0}}} : {slot_empty, slot_key};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[idx_reg];
    end

    // Advance the clearing row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
        end
    end

    // Lookup working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg  <= key_in;
            n_reg    <= n_cfg;
            div_reg  <= MOD_PAD_W'(key_in);
            rem_reg  <= '0;
            pcnt_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
            idx_reg <= IDX_W'(rem_next);
        end
        if (cmd.advance)
        begin
            idx_reg  <= idx_wrap;
            pcnt_reg <= pcnt_reg + TSIZE_W'(1);
        end
        if (cmd.finish)
        begin
            found_reg <= status.probe_match;
            hit_reg   <= status.probe_match ? SLOT_W'(idx_reg) : '0;
        end
        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_hit_reg   <= hit_reg;
            out_key_reg   <= key_reg;
        end
    end

    // Status toward the controller
    assign status.clr_last    = (clr_addr_reg == LAST_ADDR);
    assign status.probe_empty = rd_reg[KEY_W];
    assign status.probe_match = !rd_reg[KEY_W] && (rd_reg[KEY_W-1:0] == key_reg);
    assign status.probe_last  = ((pcnt_reg + TSIZE_W'(1)) == n_reg);

    assign found     = out_found_reg;
    assign hit_slot  = out_hit_reg;
    assign chunk_key = out_key_reg;

endmodule

// File: rtl/morton_chunk_hash_lookup.sv
// ----------------------------------------------------------------------------
// morton_chunk_hash_lookup: Morton-keyed chunk hash table with linear probing
// Configuration registers, controller and datapath of the lookup block.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table once, writing every slot empty,
// and takes no word during the sweep (configuration writes go through as
// usual). A load word writes one slot in the cycle it is accepted and the next
// word can follow at once. A lookup word shifts its coordinates, interleaves
// them into a 30-bit Morton key, and then steps through the digit-serial
// key-modulo-size unit, reads and checks one slot per probe on the registered
// read port of the slot memory, and hands the result to the output register;
// the input stays closed for the whole lookup of p probes (1 up to the table
// size in use). The output register holds a result until it is taken while
// the next word is already being worked on; a lookup that finishes while that
// result still waits holds in its final state, with the input closed, until
// the result is taken.
module morton_chunk_hash_lookup import mchl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AXIS_BITS   = AXIS_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    mchl_in_if.sink               in_ch,
    mchl_out_if.source            out_ch
);

    logic [SHIFT_W-1:0] chunk_shift_reg;
    logic [TSIZE_W-1:0] table_size_reg;
    mchl_cmd_t          cmd;
    mchl_status_t       status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_shift_reg <= CHUNK_SHIFT_RST;
            table_size_reg  <= TABLE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHUNK_SHIFT: chunk_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                CFG_TABLE_SIZE:  table_size_reg  <= cfg_wdata[TSIZE_W-1:0];
            endcase
        end
    end

    mchl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mchl_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AXIS_BITS   (AXIS_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .chunk_shift (chunk_shift_reg),
        .table_size  (table_size_reg),
        .pos_x       (in_ch.pos_x),
        .pos_y       (in_ch.pos_y),
        .pos_z       (in_ch.pos_z),
        .slot_number (in_ch.slot_number),
        .slot_key    (in_ch.slot_key),
        .slot_empty  (in_ch.slot_empty),
        .found       (out_ch.found),
        .hit_slot    (out_ch.hit_slot),
        .chunk_key   (out_ch.chunk_key)
    );

    // A lookup closes the input for the following cycle
    a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && (in_ch.func == FUNC_LOOKUP) |=> !in_ch.ready)
        else $error("input reopened right after a lookup word");

    // Never overwrite a result word that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_ch.valid || out_ch.ready)
        else $error("result word overwritten before it was taken");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_wr, cmd.load_wr, cmd.capture, cmd.mod_step,
                  cmd.advance, cmd.finish, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

// File: tb/morton_chunk_hash_lookup_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morton_chunk_hash_lookup_test: self-checking bench for the chunk hash lookup
// Drives load and lookup words through the input channel. A model of the slot
// table predicts the result of each lookup that the directed table gives no
// expected result for, and each result word is compared with its prediction in
// order. A short table of directed rows comes first, followed by random phases
// under several register settings. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module morton_chunk_hash_lookup_test;
    import mchl_pkg::*;

    localparam int SLOTS         = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 13;
    localparam int PHASE_WORDS   = 50;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        bit                        func;
        bit signed [COORD_W-1:0]   pos_x;
        bit signed [COORD_W-1:0]   pos_y;
        bit signed [COORD_W-1:0]   pos_z;
        bit [SLOT_W-1:0]           slot_number;
        bit [KEY_W-1:0]            slot_key;
        bit                        slot_empty;
    } table_word_t;

    typedef struct {
        bit              found;
        bit [SLOT_W-1:0] hit_slot;
        bit [KEY_W-1:0]  chunk_key;
    } chunk_result_t;

    typedef enum bit {ROW_WORD, ROW_SETUP} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        table_word_t        word;
        bit                 typed;
        chunk_result_t      want;
        bit [SHIFT_W-1:0]   chunk_shift;
        bit [TSIZE_W-1:0]   table_size;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    mchl_in_if  in_ch ();
    mchl_out_if out_ch ();

    morton_chunk_hash_lookup uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Slot table model and register copies
    bit [KEY_W-1:0]   slot_keys [SLOTS];
    bit               slot_vacant [SLOTS];
    bit [SHIFT_W-1:0] cur_shift;
    bit [TSIZE_W-1:0] cur_size;

    chunk_result_t    pending_results [$];
    bit [KEY_W-1:0]   known_keys [$];
    directed_row_t    directed [$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int hold_requests = 0;
    bit src_steady    = 1'b0;
    bit sink_steady   = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Slots in use, clamped to 1..depth
    function automatic int live_slots();
        int n;
        n = cur_size;
        if (n == 0)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        return n;
    endfunction

    // Shift each coordinate to chunk units and interleave the low axis bits
    function automatic bit [KEY_W-1:0] chunk_key_of(input bit signed [COORD_W-1:0] px,
                                                    input bit signed [COORD_W-1:0] py,
                                                    input bit signed [COORD_W-1:0] pz);
        bit signed [COORD_W-1:0] chunk [3];
        bit [KEY_W-1:0]          key;
        chunk[0] = px >>> cur_shift;
        chunk[1] = py >>> cur_shift;
        chunk[2] = pz >>> cur_shift;
        for (int b = 0; b < KEY_W; b++)
            key[b] = chunk[b % 3][b / 3];
        return key;
    endfunction

    // Walk from the home slot until a match, a vacant slot or a full lap
    function automatic chunk_result_t probe_table(input bit [KEY_W-1:0] key);
        chunk_result_t r;
        int            n;
        int            i;
        n = live_slots();
        i = int'(key) % n;
        r.found     = 1'b0;
        r.hit_slot  = '0;
        r.chunk_key = key;
        for (int p = 0; p < n; p++)
        begin
            if (slot_vacant[i])
                break;
            if (slot_keys[i] == key)
            begin
                r.found    = 1'b1;
                r.hit_slot = SLOT_W'(i);
                break;
            end
            i = (i + 1) % n;
        end
        return r;
    endfunction

    // Advance the table model by one accepted word
    function automatic void apply_word(input table_word_t w, output bit has_result,
                                       output chunk_result_t res);
        has_result = 1'b0;
        res        = '{default: 0};
        if (w.func == FUNC_LOAD)
        begin
            slot_keys[w.slot_number]   = w.slot_key;
            slot_vacant[w.slot_number] = w.slot_empty;
            if (!w.slot_empty)
            begin
                known_keys.push_back(w.slot_key);
                if (known_keys.size() > SLOTS)
                    void'(known_keys.pop_front());
            end
        end
        else
        begin
            has_result = 1'b1;
            res = probe_table(chunk_key_of(w.pos_x, w.pos_y, w.pos_z));
        end
    endfunction

    // Mostly short idle runs, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Place a chunk coordinate at the current shift, random bits elsewhere
    function automatic bit signed [COORD_W-1:0] coord_for(input bit [KEY_AXIS_W-1:0] c);
        bit [COORD_W-1:0] keep;
        keep = ~(32'h3FF << cur_shift);
        return ($urandom & keep) | (COORD_W'(c) << cur_shift);
    endfunction

    function automatic bit signed [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random word: loads mostly near the home slot, lookups mostly of stored keys
    function automatic table_word_t random_word();
        table_word_t         w;
        bit [KEY_W-1:0]      key;
        bit [KEY_AXIS_W-1:0] axis [3];
        int                  n;
        int                  pick;
        n = live_slots();
        w.pos_x       = $urandom;
        w.pos_y       = $urandom;
        w.pos_z       = $urandom;
        w.slot_number = SLOT_W'($urandom_range(0, SLOTS - 1));
        w.slot_key    = KEY_W'($urandom);
        w.slot_empty  = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            w.func = FUNC_LOAD;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                w.slot_number = SLOT_W'((int'(w.slot_key) % n + $urandom_range(0, 3)) % n);
            else if (pick < 70)
                w.slot_number = SLOT_W'(n - 1);
            else if (pick < 75)
                w.slot_number = '1;
        end
        else
        begin
            w.func = FUNC_LOOKUP;
            pick = $urandom_range(0, 99);
            if (pick < 55 && known_keys.size() != 0)
            begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                for (int b = 0; b < KEY_W; b++)
                    axis[b % 3][b / 3] = key[b];
                w.pos_x = coord_for(axis[0]);
                w.pos_y = coord_for(axis[1]);
                w.pos_z = coord_for(axis[2]);
            end
            else if (pick >= 90)
            begin
                w.pos_x = extreme_coord();
                w.pos_y = extreme_coord();
                w.pos_z = extreme_coord();
            end
        end
        return w;
    endfunction

    // Directed table rows
    function automatic directed_row_t lookup_row(input int px, input int py, input int pz);
        directed_row_t row;
        row.kind       = ROW_WORD;
        row.word.func  = FUNC_LOOKUP;
        row.word.pos_x = px;
        row.word.pos_y = py;
        row.word.pos_z = pz;
        return row;
    endfunction

    function automatic directed_row_t checked_row(input int px, input int py, input int pz,
                                                  input bit found, input int slot,
                                                  input int key);
        directed_row_t row;
        row = lookup_row(px, py, pz);
        row.typed          = 1'b1;
        row.want.found     = found;
        row.want.hit_slot  = SLOT_W'(slot);
        row.want.chunk_key = KEY_W'(key);
        return row;
    endfunction

    function automatic directed_row_t load_row(input int slot, input int key, input bit vacant);
        directed_row_t row;
        row.kind             = ROW_WORD;
        row.word.func        = FUNC_LOAD;
        row.word.slot_number = SLOT_W'(slot);
        row.word.slot_key    = KEY_W'(key);
        row.word.slot_empty  = vacant;
        return row;
    endfunction

    function automatic directed_row_t setup_row(input int sh, input int sz);
        directed_row_t row;
        row.kind        = ROW_SETUP;
        row.chunk_shift = SHIFT_W'(sh);
        row.table_size  = TSIZE_W'(sz);
        return row;
    endfunction

    // Offer one word, hold it until taken, then predict its result
    task automatic send_word(input table_word_t w, input bit typed, input chunk_result_t want);
        int            gap;
        bit            has_result;
        chunk_result_t res;
        gap = 0;
        if (!src_steady && $urandom_range(0, 1) == 1)
            gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= w.func;
        in_ch.pos_x       <= w.pos_x;
        in_ch.pos_y       <= w.pos_y;
        in_ch.pos_z       <= w.pos_z;
        in_ch.slot_number <= w.slot_number;
        in_ch.slot_key    <= w.slot_key;
        in_ch.slot_empty  <= w.slot_empty;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        apply_word(w, has_result, res);
        if (has_result)
            pending_results.push_back(typed ? want : res);
    endtask

    // Drop valid and wait until the block has nothing left in flight
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers once the block is idle
    task automatic apply_setup(input bit [SHIFT_W-1:0] sh, input bit [TSIZE_W-1:0] sz);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHUNK_SHIFT;
        cfg_wdata <= CFG_DATA_W'(sh);
        @(posedge clk);
        cfg_index <= CFG_TABLE_SIZE;
        cfg_wdata <= CFG_DATA_W'(sz);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_shift = sh;
        cur_size  = sz;
        @(posedge clk);
    endtask

    // Result side: random ready runs, steady stretches and long holds
    initial
    begin : result_sink
        int run_left;
        int hold_left;
        int holds_served;
        bit rdy;
        run_left     = 0;
        hold_left    = 0;
        holds_served = 0;
        rdy          = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (sink_steady)
                rdy = 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    rdy = ($urandom_range(0, 99) < 65);
                    run_left = rdy ? $urandom_range(1, 20) : gap_len();
                end
                run_left--;
            end
            out_ch.ready <= rdy;
        end
    end

    // Compare every result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        chunk_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with no lookup pending: found=%0b hit_slot=%0d chunk_key=%h",
                             $time, out_ch.found, out_ch.hit_slot, out_ch.chunk_key);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.found !== want.found || out_ch.hit_slot !== want.hit_slot ||
                    out_ch.chunk_key !== want.chunk_key)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected found=%0b hit_slot=%0d chunk_key=%h, got found=%0b hit_slot=%0d chunk_key=%h",
                                 $time, want.found, want.hit_slot, want.chunk_key,
                                 out_ch.found, out_ch.hit_slot, out_ch.chunk_key);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
        cycle_count++;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        chunk_result_t    no_want;
        bit [SHIFT_W-1:0] sh;
        bit [TSIZE_W-1:0] sz;
        int               pick;
        no_want = '{default: 0};

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_CHUNK_SHIFT;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= FUNC_LOAD;
        in_ch.pos_x       <= '0;
        in_ch.pos_y       <= '0;
        in_ch.pos_z       <= '0;
        in_ch.slot_number <= '0;
        in_ch.slot_key    <= '0;
        in_ch.slot_empty  <= 1'b0;

        cur_shift = CHUNK_SHIFT_RST;
        cur_size  = TABLE_SIZE_RST;
        foreach (slot_vacant[s])
        begin
            slot_vacant[s] = 1'b1;
            slot_keys[s]   = '0;
        end

        // Reset settings: shift 5, one slot in use, every slot vacant
        directed.push_back(checked_row(0, 0, 0, 1'b0, 0, 0));
        directed.push_back(checked_row(-1, -1, -1, 1'b0, 0, 30'h3FFF_FFFF));
        directed.push_back(checked_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       1'b0, 0, 30'h3FFF_FFFF));
        directed.push_back(checked_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       1'b0, 0, 0));
        directed.push_back(checked_row(32, 0, 0, 1'b0, 0, 1));
        directed.push_back(checked_row(0, 32, 0, 1'b0, 0, 2));
        directed.push_back(checked_row(0, 0, 32, 1'b0, 0, 4));
        // Hit in slot 0, then a full one-slot table without the key
        directed.push_back(load_row(0, 1, 1'b0));
        directed.push_back(checked_row(63, 0, 0, 1'b1, 0, 1));
        directed.push_back(checked_row(0, 0, 0, 1'b0, 0, 0));
        // A slot loaded as vacant keeps its key but never matches it
        directed.push_back(load_row(0, 0, 1'b1));
        directed.push_back(checked_row(0, 0, 0, 1'b0, 0, 0));
        directed.push_back(load_row(63, 30'h3FFF_FFFF, 1'b0));
        // No shift, full depth: top slot hit, wrap from the top slot to slot 0
        directed.push_back(setup_row(0, SLOTS));
        directed.push_back(checked_row(1, 1, 1, 1'b0, 0, 7));
        directed.push_back(checked_row(32'h3FF, 32'h3FF, 32'h3FF, 1'b1, 63, 30'h3FFF_FFFF));
        directed.push_back(load_row(0, 127, 1'b0));
        directed.push_back(checked_row(7, 3, 3, 1'b1, 0, 127));
        directed.push_back(load_row(7, 5, 1'b0));
        directed.push_back(checked_row(1, 1, 1, 1'b0, 0, 7));
        // Largest shift with a size of zero, which acts as one slot
        directed.push_back(setup_row(15, 0));
        directed.push_back(checked_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       1'b0, 0, 30'h3FFF_FFFF));
        directed.push_back(checked_row(-32768, 0, 0, 1'b0, 0, 30'h0924_9249));
        // Size above depth acts as full depth
        directed.push_back(setup_row(8, 127));
        directed.push_back(lookup_row(1280, -256, 1000));
        directed.push_back(checked_row(32'h0003_FF00, 32'h0003_FF00, 32'h0003_FF00,
                                       1'b1, 63, 30'h3FFF_FFFF));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed[r])
        begin
            if (directed[r].kind == ROW_SETUP)
                apply_setup(directed[r].chunk_shift, directed[r].table_size);
            else
                send_word(directed[r].word, directed[r].typed, directed[r].want);
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin sh = 0;  sz = SLOTS; end
                1:       begin sh = 15; sz = 1;     end
                2:       begin sh = 8;  sz = '1;    end
                3:       begin sh = 0;  sz = 0;     end
                default:
                begin
                    sh   = SHIFT_W'($urandom_range(0, 15));
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        sz = TSIZE_W'($urandom_range(1, 8));
                    else if (pick < 9)
                        sz = TSIZE_W'($urandom_range(9, SLOTS));
                    else
                        sz = TSIZE_W'($urandom_range(SLOTS + 1, 127));
                end
            endcase
            apply_setup(sh, sz);
            src_steady  = (phase == 4 || phase == 6);
            sink_steady = (phase == 4);
            // Hold the result side while words keep coming
            if (phase == 6)
                hold_requests++;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Pause mid-phase until every result is back
                if (phase == 8 && n == PHASE_WORDS / 2)
                    drain_results();
                send_word(random_word(), 1'b0, no_want);
            end
        end

        src_steady  = 1'b0;
        sink_steady = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/mchl_pkg.sv
rtl/mchl_in_if.sv
rtl/mchl_out_if.sv
rtl/mchl_ctrl.sv
rtl/mchl_dpath.sv
rtl/morton_chunk_hash_lookup.sv
tb/morton_chunk_hash_lookup_test.sv
